// ----- src/tpsd_pkg.sv -----
// Package for the two-phase sine PWM duty core.
// Holds the event codes, the sine ROM word type and the duty constants.
// No dependencies.
package tpsd_pkg;

	typedef enum logic [1:0] {
		KIND_TICK    = 2'd0,
		KIND_START   = 2'd1,
		KIND_STOP    = 2'd2,
		KIND_SET_AMP = 2'd3
	} kind_t;

	// One sine ROM word: sign and Q0.15 magnitude
	typedef struct packed {
		logic        neg;
		logic [14:0] mag;
	} sine_t;

	localparam logic [14:0] MIDPOINT   = 15'd12800;
	localparam logic [13:0] AMP_CEIL   = 14'd12800;
	localparam logic [29:0] ROUND_HALF = 30'd16384;

	// Result queue depth and its pointer / count widths
	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_PW    = 2;
	localparam int unsigned Q_CW    = 3;

endpackage

// ----- src/tpsd_sine_rom.sv -----
// Sine ROM for the two-phase sine PWM duty core, two registered read ports.
// Contents are built at elaboration from TABLE_SIZE. Depends on tpsd_pkg.
module tpsd_sine_rom import tpsd_pkg::*; #(
	parameter int unsigned TABLE_SIZE = 400
) (
	input  logic                          clk,
	input  logic [$clog2(TABLE_SIZE)-1:0] addr_a,
	input  logic [$clog2(TABLE_SIZE)-1:0] addr_b,
	output sine_t                         data_a,
	output sine_t                         data_b
);

	localparam logic [63:0] ONE_Q30     = 64'd1073741824;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] FULL_SCALE  = 64'd32767;
	localparam logic [63:0] RND_Q30     = 64'd536870912;

	// Q30 Taylor series by Horner's rule, each step truncating
	function automatic sine_t sine_entry(input int unsigned idx);
		logic [63:0] n, q, r, x, theta, t2, p, v;
		sine_t e;
		n = 64'(idx) * 64'd4;
		q = n / TABLE_SIZE;
		r = n % TABLE_SIZE;
		x = (r << 30) / TABLE_SIZE;
		theta = (x * HALF_PI_Q30) >> 30;
		t2 = (theta * theta) >> 30;
		p = ONE_Q30;
		if (q[0]) begin
			p = ONE_Q30 - ((t2 * p) >> 30) / 64'd90;
			p = ONE_Q30 - ((t2 * p) >> 30) / 64'd56;
			p = ONE_Q30 - ((t2 * p) >> 30) / 64'd30;
			p = ONE_Q30 - ((t2 * p) >> 30) / 64'd12;
			p = ONE_Q30 - ((t2 * p) >> 30) / 64'd2;
		end else begin
			p = ONE_Q30 - ((t2 * p) >> 30) / 64'd110;
			p = ONE_Q30 - ((t2 * p) >> 30) / 64'd72;
			p = ONE_Q30 - ((t2 * p) >> 30) / 64'd42;
			p = ONE_Q30 - ((t2 * p) >> 30) / 64'd20;
			p = ONE_Q30 - ((t2 * p) >> 30) / 64'd6;
			p = (p * theta) >> 30;
		end
		v = (p > ONE_Q30) ? ONE_Q30 : p;
		v = (v * FULL_SCALE + RND_Q30) >> 30;
		e.neg = q[1];
		e.mag = v[14:0];
		return e;
	endfunction

	sine_t rom_tbl [TABLE_SIZE];

	for (genvar i = 0; i < TABLE_SIZE; i++) begin : g_rom
		localparam sine_t ENTRY = sine_entry(i);
		assign rom_tbl[i] = ENTRY;
	end

	always_ff @(posedge clk) begin
		data_a <= rom_tbl[addr_a];
		data_b <= rom_tbl[addr_b];
	end

endmodule

// ----- src/two_phase_sine_pwm_duty_core.sv -----
// Two-phase sine PWM duty core: event decode, phase state, duty pipeline and
// result queue. Depends on tpsd_pkg and tpsd_sine_rom.
//
// channel       dir  handshake                     payload
// s_axis        in   s_axis_tvalid/s_axis_tready   tuser: kind, tdata: amplitude
// m_axis        out  m_axis_tvalid/m_axis_tready   tdata: duty_first, duty_second
// cfg           in   cfg_wr_en                     cfg_wr_data: max_amplitude
//
// One request per cycle while s_axis_tready is high. An enabled tick or a stop raises
// m_axis_tvalid after the ROM read, the multiply, then the round and offset into a
// 4-entry result queue.
// s_axis_tready drops while queue entries plus in-flight results reach 4.
// arst_n resets the phase state, amplitude, limit register, pipeline and queue.
module two_phase_sine_pwm_duty_core import tpsd_pkg::*; #(
	parameter int unsigned TABLE_SIZE      = 400,
	parameter int unsigned START_AMPLITUDE = 0
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [13:0] amplitude
	input  logic [1:0]  s_axis_tuser,   // [1:0] kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [14:0] duty_first, [29:15] duty_second
	input  logic        cfg_wr_en,
	input  logic [13:0] cfg_wr_data     // max_amplitude
);

	localparam int unsigned PW = $clog2(TABLE_SIZE);
	localparam logic [PW-1:0] HALF = PW'(TABLE_SIZE / 2);
	localparam logic [PW:0]   SIZE_W = (PW + 1)'(TABLE_SIZE);

	logic [13:0]   max_amp_q;
	logic          enabled_q;
	logic [PW-1:0] phase_first_q;
	logic [PW-1:0] phase_second_q;
	logic [13:0]   amp_now_q;

	logic          accept;
	kind_t         kind;
	logic [13:0]   req_amp;
	logic [PW-1:0] pf_inc;
	logic [PW-1:0] ps_inc;
	logic [PW:0]   pf_sum;
	logic [PW:0]   ps_sum;
	logic [13:0]   amp_lim;
	logic [13:0]   amp_clamped;

	assign accept  = s_axis_tvalid & s_axis_tready;
	assign kind    = kind_t'(s_axis_tuser);
	assign req_amp = s_axis_tdata[13:0];

	always_comb begin
		pf_sum = {1'b0, phase_first_q} + (PW + 1)'(1);
		ps_sum = {1'b0, phase_second_q} + (PW + 1)'(1);
		pf_inc = (pf_sum >= SIZE_W) ? '0 : pf_sum[PW-1:0];
		ps_inc = (ps_sum >= SIZE_W) ? '0 : ps_sum[PW-1:0];
		amp_lim = (max_amp_q > AMP_CEIL) ? AMP_CEIL : max_amp_q;
		amp_clamped = (req_amp > amp_lim) ? amp_lim : req_amp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_amp_q <= AMP_CEIL;
		end else if (cfg_wr_en) begin
			max_amp_q <= cfg_wr_data;
		end
	end

	// Stage 1: event decode; ROM addresses are the advanced phases
	logic        valid_s1;
	logic [13:0] amp_s1;
	logic        res_item;

	assign res_item = ((kind == KIND_TICK) && enabled_q) || (kind == KIND_STOP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q      <= 1'b0;
			phase_first_q  <= '0;
			phase_second_q <= HALF;
			amp_now_q      <= 14'(START_AMPLITUDE);
			valid_s1       <= 1'b0;
		end else begin
			valid_s1 <= accept & res_item;
			if (accept) begin
				case (kind)
					KIND_TICK: begin
						if (enabled_q) begin
							phase_first_q  <= pf_inc;
							phase_second_q <= ps_inc;
						end else begin
							phase_first_q  <= '0;
							phase_second_q <= HALF;
							amp_now_q      <= '0;
						end
					end
					KIND_START:   enabled_q <= 1'b1;
					KIND_STOP:    enabled_q <= 1'b0;
					KIND_SET_AMP: amp_now_q <= amp_clamped;
					default:      enabled_q <= enabled_q;
				endcase
			end
		end
	end

	// A stop rides the same path with zero amplitude, which lands on midpoint
	always_ff @(posedge clk) begin
		amp_s1 <= (kind == KIND_STOP) ? '0 : amp_now_q;
	end

	sine_t sine_a_s1;
	sine_t sine_b_s1;

	tpsd_sine_rom #(
		.TABLE_SIZE(TABLE_SIZE)
	) u_rom (
		.clk    (clk),
		.addr_a (pf_inc),
		.addr_b (ps_inc),
		.data_a (sine_a_s1),
		.data_b (sine_b_s1)
	);

	// Stage 2: amplitude times sine magnitude
	logic        valid_s2;
	logic [28:0] prod_a_s2;
	logic [28:0] prod_b_s2;
	logic        neg_a_s2;
	logic        neg_b_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_a_s2 <= 29'(amp_s1) * 29'(sine_a_s1.mag);
		prod_b_s2 <= 29'(amp_s1) * 29'(sine_b_s1.mag);
		neg_a_s2  <= sine_a_s1.neg;
		neg_b_s2  <= sine_b_s1.neg;
	end

	// Stage 3: symmetric rounding, clamp and offset from midpoint
	logic [29:0] rnd_a;
	logic [29:0] rnd_b;
	logic [14:0] m_a;
	logic [14:0] m_b;
	logic [14:0] duty_a;
	logic [14:0] duty_b;

	always_comb begin
		rnd_a = 30'(prod_a_s2) + ROUND_HALF;
		rnd_b = 30'(prod_b_s2) + ROUND_HALF;
		m_a = (rnd_a[29:15] > MIDPOINT) ? MIDPOINT : rnd_a[29:15];
		m_b = (rnd_b[29:15] > MIDPOINT) ? MIDPOINT : rnd_b[29:15];
		duty_a = neg_a_s2 ? (MIDPOINT - m_a) : (MIDPOINT + m_a);
		duty_b = neg_b_s2 ? (MIDPOINT - m_b) : (MIDPOINT + m_b);
	end

	// Result queue; credit covers entries held plus results still in flight
	logic [29:0]     q_mem [Q_DEPTH];
	logic [Q_PW-1:0] wr_ptr_q;
	logic [Q_PW-1:0] rd_ptr_q;
	logic [Q_CW-1:0] count_q;
	logic [Q_CW-1:0] occupancy;
	logic            pop;

	assign pop       = m_axis_tvalid & m_axis_tready;
	assign occupancy = count_q + Q_CW'(valid_s1) + Q_CW'(valid_s2);
	assign s_axis_tready = (occupancy < Q_CW'(Q_DEPTH));
	assign m_axis_tvalid = (count_q != '0);
	assign m_axis_tdata  = {2'b00, q_mem[rd_ptr_q]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (valid_s2) begin
				wr_ptr_q <= wr_ptr_q + Q_PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PW'(1);
			end
			count_q <= count_q + Q_CW'(valid_s2) - Q_CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			q_mem[wr_ptr_q] <= {duty_b, duty_a};
		end
	end

`ifndef SYNTHESIS
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occupancy <= Q_CW'(Q_DEPTH))
		else $error("result queue credit overrun");

	a_phase_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_first_q < PW'(TABLE_SIZE - TABLE_SIZE / 2)) ?
			(phase_second_q == phase_first_q + HALF) :
			(phase_second_q == phase_first_q - PW'(TABLE_SIZE - TABLE_SIZE / 2)))
		else $error("phases lost their half-period offset");

	a_tick_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (kind == KIND_TICK) && enabled_q |=> valid_s1 ##1 valid_s2)
		else $error("enabled tick produced no result");

	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (duty_a <= 15'd25600) && (duty_b <= 15'd25600))
		else $error("duty out of range");
`endif

endmodule

// ----- dv/testbench.sv -----
// Testbench for two_phase_sine_pwm_duty_core: directed event table, then random
// event streams under several amplitude limits, checked against a duty predictor.
// Depends on tpsd_pkg and the core RTL.
module testbench;
	import tpsd_pkg::*;

	localparam int unsigned TBL         = 400;
	localparam int unsigned START_AMP   = 0;
	localparam int unsigned LAT         = 3;
	localparam int unsigned STALL_LIMIT = 1000;
	localparam int unsigned HOLD_CYCLES = 80;
	localparam longint unsigned Q30_ONE     = 64'd1073741824;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef struct packed {
		logic [14:0] first;
		logic [14:0] second;
	} duty_pair_t;

	typedef struct packed {
		kind_t       kind;
		logic [13:0] amp;
		logic        typed;
		logic [14:0] first;
		logic [14:0] second;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic        cfg_wr_en;
	logic [13:0] cfg_wr_data;

	// typed expectation travels with the request it belongs to
	logic        tag_on;
	logic [14:0] tag_first;
	logic [14:0] tag_second;

	// predictor state
	bit          mdl_en      = 1'b0;
	int unsigned mdl_ph_a    = 0;
	int unsigned mdl_ph_b    = TBL / 2;
	logic [13:0] mdl_amp     = 14'(START_AMP);
	logic [13:0] mdl_limit   = 14'd12800;

	duty_pair_t  duty_q [$];
	int unsigned fail_cnt    = 0;
	int unsigned report_cnt  = 0;
	int unsigned idle_cycles = 0;
	bit          burst_mode  = 1'b0;
	bit          rx_hold_req = 1'b0;

	localparam logic [14:0] MID = MIDPOINT;

	dir_row_t dir_rows [0:21] = '{
		'{KIND_TICK,    14'h3FFF, 1'b0, 15'd0, 15'd0},   // tick while disabled
		'{KIND_STOP,    14'h0000, 1'b1, MID,   MID},     // stop while disabled
		'{KIND_START,   14'h1555, 1'b0, 15'd0, 15'd0},
		'{KIND_TICK,    14'h2AAA, 1'b1, MID,   MID},     // amplitude still zero
		'{KIND_START,   14'h3FFF, 1'b0, 15'd0, 15'd0},   // start while enabled
		'{KIND_SET_AMP, 14'd12800, 1'b0, 15'd0, 15'd0},
		'{KIND_TICK,    14'h0000, 1'b0, 15'd0, 15'd0},
		'{KIND_TICK,    14'h3FFF, 1'b0, 15'd0, 15'd0},
		'{KIND_SET_AMP, 14'h3FFF, 1'b0, 15'd0, 15'd0},   // above range, clamps
		'{KIND_TICK,    14'h0000, 1'b0, 15'd0, 15'd0},
		'{KIND_SET_AMP, 14'h0000, 1'b0, 15'd0, 15'd0},
		'{KIND_TICK,    14'h1234, 1'b1, MID,   MID},
		'{KIND_SET_AMP, 14'd1,    1'b0, 15'd0, 15'd0},
		'{KIND_TICK,    14'h0000, 1'b0, 15'd0, 15'd0},
		'{KIND_STOP,    14'h3FFF, 1'b1, MID,   MID},
		'{KIND_SET_AMP, 14'd5000, 1'b0, 15'd0, 15'd0},   // set while disabled
		'{KIND_TICK,    14'h0000, 1'b0, 15'd0, 15'd0},   // zeroes it again
		'{KIND_START,   14'h0000, 1'b0, 15'd0, 15'd0},
		'{KIND_TICK,    14'h3FFF, 1'b1, MID,   MID},
		'{KIND_SET_AMP, 14'h2AAA, 1'b0, 15'd0, 15'd0},
		'{KIND_TICK,    14'h1555, 1'b0, 15'd0, 15'd0},
		'{KIND_STOP,    14'h0000, 1'b1, MID,   MID}
	};

	two_phase_sine_pwm_duty_core #(
		.TABLE_SIZE      (TBL),
		.START_AMPLITUDE (START_AMP)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Q1.15 sine table entry, evaluated as a truncating Q30 Taylor series
	function automatic sine_t sine_at(input int unsigned idx);
		longint unsigned n, q, r, x, theta, t2, p, k, v;
		sine_t s;
		n = idx;
		n = n * 4;
		q = n / TBL;
		r = n % TBL;
		x = (r << 30) / TBL;
		theta = (x * HALF_PI_Q30) >> 30;
		t2 = (theta * theta) >> 30;
		p = Q30_ONE;
		k = q[0] ? 64'd9 : 64'd10;
		while (k >= 1) begin
			p = Q30_ONE - ((t2 * p) >> 30) / (k * (k + 1));
			if (k < 2)
				break;
			k = k - 2;
		end
		if (!q[0])
			p = (p * theta) >> 30;
		v = (p > Q30_ONE) ? Q30_ONE : p;
		v = (v * 32767 + (64'd1 << 29)) >> 30;
		s.neg = q[1];
		s.mag = v[14:0];
		return s;
	endfunction

	function automatic logic [14:0] duty_at(input int unsigned idx);
		sine_t s;
		longint unsigned m;
		s = sine_at(idx);
		m = mdl_amp;
		m = (m * s.mag + ROUND_HALF) >> 15;
		if (m > MIDPOINT)
			m = MIDPOINT;
		return s.neg ? MIDPOINT - m[14:0] : MIDPOINT + m[14:0];
	endfunction

	// advances the predictor by one request; returns 1 when a duty pair comes out
	function automatic bit predict_duty(input kind_t k, input logic [13:0] a,
			output duty_pair_t d);
		logic [13:0] lim;
		d = '0;
		case (k)
			KIND_TICK: begin
				if (!mdl_en) begin
					mdl_ph_a = 0;
					mdl_ph_b = TBL / 2;
					mdl_amp  = '0;
					return 1'b0;
				end
				mdl_ph_a = (mdl_ph_a + 1 >= TBL) ? 0 : mdl_ph_a + 1;
				mdl_ph_b = (mdl_ph_b + 1 >= TBL) ? 0 : mdl_ph_b + 1;
				d.first  = duty_at(mdl_ph_a);
				d.second = duty_at(mdl_ph_b);
				return 1'b1;
			end
			KIND_START: begin
				mdl_en = 1'b1;
				return 1'b0;
			end
			KIND_STOP: begin
				mdl_en   = 1'b0;
				d.first  = MIDPOINT;
				d.second = MIDPOINT;
				return 1'b1;
			end
			default: begin
				lim = (mdl_limit > AMP_CEIL) ? AMP_CEIL : mdl_limit;
				mdl_amp = (a > lim) ? lim : a;
				return 1'b0;
			end
		endcase
	endfunction

	// request side predicts, result side checks against the oldest pair
	always @(posedge clk) begin
		duty_pair_t pd;
		duty_pair_t got;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.first  = m_axis_tdata[14:0];
				got.second = m_axis_tdata[29:15];
				if (duty_q.size() == 0) begin
					fail_cnt++;
					if (report_cnt < 10) begin
						report_cnt++;
						$display("unexpected result %0d/%0d", got.first, got.second);
					end
				end else begin
					pd = duty_q.pop_front();
					if (pd != got) begin
						fail_cnt++;
						if (report_cnt < 10) begin
							report_cnt++;
							$display("mismatch: expected %0d/%0d, got %0d/%0d",
								pd.first, pd.second, got.first, got.second);
						end
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (predict_duty(kind_t'(s_axis_tuser), s_axis_tdata[13:0], pd)) begin
					if (tag_on) begin
						pd.first  = tag_first;
						pd.second = tag_second;
					end
					duty_q.push_back(pd);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wr_en)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	// result side: random back-pressure, plus one long hold-off on request
	initial begin
		int unsigned wait_cycles;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			wait_cycles = burst_mode ? 0 : $urandom_range(0, 12);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				wait_cycles = wait_cycles + HOLD_CYCLES;
			end
			if (wait_cycles != 0) begin
				m_axis_tready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid)
				@(posedge clk);
		end
	end

	task automatic send_req(input kind_t k, input logic [13:0] a, input logic typed,
			input logic [14:0] t_first, input logic [14:0] t_second);
		int unsigned gap;
		gap = burst_mode ? 0 : $urandom_range(0, 12);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= k;
		s_axis_tdata  <= {2'b00, a};
		tag_on        <= typed;
		tag_first     <= t_first;
		tag_second    <= t_second;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic send_random(input int unsigned w_tick, input int unsigned w_start,
			input int unsigned w_stop);
		int unsigned r;
		logic [13:0] a;
		r = $urandom_range(0, 99);
		a = 14'($urandom_range(0, 16383));
		if (r < w_tick)
			send_req(KIND_TICK, a, 1'b0, '0, '0);
		else if (r < w_tick + w_start)
			send_req(KIND_START, a, 1'b0, '0, '0);
		else if (r < w_tick + w_start + w_stop)
			send_req(KIND_STOP, a, 1'b0, '0, '0);
		else begin
			if ($urandom_range(0, 4) != 0)
				a = 14'($urandom_range(0, 12800));
			send_req(KIND_SET_AMP, a, 1'b0, '0, '0);
		end
	endtask

	// waits for every pending duty pair, then for requests that give none
	task automatic drain();
		while (duty_q.size() != 0)
			@(posedge clk);
		repeat (LAT + 2) @(posedge clk);
	endtask

	task automatic write_limit(input logic [13:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		mdl_limit = v;
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		logic [13:0] limits [0:4];
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= KIND_TICK;
		tag_on        <= 1'b0;
		tag_first     <= '0;
		tag_second    <= '0;
		cfg_wr_en     <= 1'b0;
		cfg_wr_data   <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_req(dir_rows[i].kind, dir_rows[i].amp, dir_rows[i].typed,
				dir_rows[i].first, dir_rows[i].second);
		s_axis_tvalid <= 1'b0;
		drain();

		// long enabled run: wraps both indices, includes a back-pressure burst
		write_limit(14'd12800);
		send_req(KIND_START, 14'd0, 1'b0, '0, '0);
		send_req(KIND_SET_AMP, 14'd12800, 1'b0, '0, '0);
		for (int i = 0; i < 430; i++) begin
			if (i == 150) begin
				rx_hold_req = 1'b1;
				burst_mode  = 1'b1;
			end
			if (i == 200)
				burst_mode = 1'b0;
			send_random(98, 0, 0);
		end
		send_req(KIND_STOP, 14'd0, 1'b0, '0, '0);
		s_axis_tvalid <= 1'b0;
		drain();

		limits[0] = 14'd0;
		limits[1] = 14'h3FFF;
		limits[2] = 14'd1;
		limits[3] = 14'd6400;
		limits[4] = 14'($urandom_range(0, 16383));
		foreach (limits[p]) begin
			write_limit(limits[p]);
			send_req(KIND_START, 14'($urandom_range(0, 16383)), 1'b0, '0, '0);
			for (int i = 0; i < 34; i++)
				send_random(55, 10, 12);
			s_axis_tvalid <= 1'b0;
			drain();
		end

		drain();
		if (fail_cnt == 0 && duty_q.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
